// ===== sv/dq_pkg.sv =====
// dq_pkg: shared types and constants for the double-ended queue
// used by dq_ptr, double_ended_queue and dq_check; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int DATA_W           = 32;
    localparam int COUNT_W          = 5;
    localparam int S_TDATA_W        = 32;
    localparam int S_TUSER_W        = 2;
    localparam int M_TDATA_W        = 72;

    localparam logic [DATA_W-1:0] EMPTY_READ = '1;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LOOK = 2'b10
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic overflow;
    } upd_flags_t;

endpackage

`default_nettype wire

// ===== sv/dq_ram.sv =====
// dq_ram: generic single-write, single-read synchronous ram, registered read
// read during write to the same address returns the old contents; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/dq_ptr.sv =====
// dq_ptr: head, tail and count registers of the ring, with the update per operation
// depends on dq_pkg
`timescale 1ns / 1ps
`default_nettype none

module dq_ptr #(
    parameter int CAPACITY = dq_pkg::DEFAULT_CAPACITY
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            upd_en,
    input  wire dq_pkg::op_t                     op,
    output dq_pkg::upd_flags_t                   flags,
    output logic [$clog2(CAPACITY)-1:0]          wr_addr,
    output logic [$clog2(CAPACITY)-1:0]          front_addr,
    output logic [$clog2(CAPACITY)-1:0]          back_addr,
    output logic [$clog2(CAPACITY+1)-1:0]        count_new
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             full;
    logic             empty;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(CAPACITY - 1)) ? '0 : i + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(CAPACITY - 1) : i - IDX_W'(1);
    endfunction

    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);

    always_comb begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        wr_addr        = tail_reg;
        flags.wr_en    = 1'b0;
        flags.overflow = 1'b0;
        case (op)
            dq_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    flags.overflow = 1'b1;
                end else begin
                    head_next   = ring_prev(head_reg);
                    wr_addr     = head_next;
                    flags.wr_en = 1'b1;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            dq_pkg::OP_PUSH_BACK: begin
                if (full) begin
                    flags.overflow = 1'b1;
                end else begin
                    wr_addr     = tail_reg;
                    tail_next   = ring_next(tail_reg);
                    flags.wr_en = 1'b1;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            dq_pkg::OP_POP_FRONT: begin
                if (!empty) begin
                    head_next  = ring_next(head_reg);
                    count_next = count_reg - CNT_W'(1);
                end
            end
            dq_pkg::OP_POP_BACK: begin
                if (!empty) begin
                    tail_next  = ring_prev(tail_reg);
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default: begin
                head_next = head_reg;
            end
        endcase
    end

    // tail points one past the back value; with no update the current ends are read
    assign front_addr = upd_en ? head_next : head_reg;
    assign back_addr  = upd_en ? ring_prev(tail_next) : ring_prev(tail_reg);
    assign count_new  = count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else if (upd_en) begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/double_ended_queue.sv =====
// double_ended_queue: bounded deque of signed 32-bit words, front and back reported per word
// Input words carry an operation on s_tuser (push front, push back, pop front,
// pop back) and a value on s_tdata. Every accepted word produces exactly one
// result word on m_tdata: front value, back value, count, empty flag and an
// overflow flag set when a push met a full queue and was dropped. A pop on an
// empty queue leaves the queue as it was. An empty queue reads -1 at both ends.
// A word is not taken before the result of the word ahead of it has been loaded
// into the output register; the ring store is a ram with a registered read, so
// the new end values are registered when the word is taken, and the output
// register loads them in ST_LOOK while s_tready is low.
// The output register holds a finished result while the input side takes the
// next word; if the receiver holds m_tready low, s_tready drops after that
// next word until the result is taken.
// Reset (aresetn low, synchronous) empties the queue and clears m_tvalid; the
// ram contents are not cleared and are never read before being written.
// Depends on dq_pkg, dq_ptr and dq_ram.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
    parameter int CAPACITY = dq_pkg::DEFAULT_CAPACITY
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [dq_pkg::S_TDATA_W-1:0]  s_tdata,   // [31:0] value
    input  wire logic [dq_pkg::S_TUSER_W-1:0]  s_tuser,   // [1:0] op
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [31:0] front_value, [63:32] back_value, [68:64] count, [69] is_empty,
    // [70] overflow, [71] zero
    output logic      [dq_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int DW    = dq_pkg::DATA_W;

    dq_pkg::state_t     state_reg, state_next;
    dq_pkg::upd_flags_t flags;

    logic             accept;
    logic             out_load;
    logic [IDX_W-1:0] wr_addr, front_addr, back_addr;
    logic [CNT_W-1:0] count_new;
    logic [DW-1:0]    rd_front, rd_back;

    logic [DW-1:0]    wdata_reg;
    logic             fwd_front_reg, fwd_back_reg;
    logic [CNT_W-1:0] count_res_reg;
    logic             ovf_res_reg;

    logic             m_tvalid_reg, m_tvalid_next;
    logic [dq_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic [DW-1:0]    front_val, back_val;
    logic             res_empty;
    logic [31:0]      count_ext;

    assign s_tready = (state_reg == dq_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == dq_pkg::ST_LOOK) && (!m_tvalid_reg || m_tready);

    dq_ptr #(
        .CAPACITY (CAPACITY)
    ) u_ptr (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .upd_en     (accept),
        .op         (dq_pkg::op_t'(s_tuser)),
        .flags      (flags),
        .wr_addr    (wr_addr),
        .front_addr (front_addr),
        .back_addr  (back_addr),
        .count_new  (count_new)
    );

    // two copies of the ring, written alike, one read port for each end
    dq_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_ram_front (
        .clk     (aclk),
        .wr_en   (accept && flags.wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_tdata),
        .rd_addr (front_addr),
        .rd_data (rd_front)
    );

    dq_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_ram_back (
        .clk     (aclk),
        .wr_en   (accept && flags.wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_tdata),
        .rd_addr (back_addr),
        .rd_data (rd_back)
    );

    // the ram returns old data when a read hits the slot being written
    always_ff @(posedge aclk) begin
        if (accept) begin
            wdata_reg     <= s_tdata;
            fwd_front_reg <= flags.wr_en && (wr_addr == front_addr);
            fwd_back_reg  <= flags.wr_en && (wr_addr == back_addr);
            count_res_reg <= count_new;
            ovf_res_reg   <= flags.overflow;
        end
    end

    assign res_empty = (count_res_reg == '0);
    assign count_ext = 32'(count_res_reg);
    assign front_val = res_empty ? dq_pkg::EMPTY_READ : (fwd_front_reg ? wdata_reg : rd_front);
    assign back_val  = res_empty ? dq_pkg::EMPTY_READ : (fwd_back_reg ? wdata_reg : rd_back);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dq_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = dq_pkg::ST_LOOK;
                end
            end
            dq_pkg::ST_LOOK: begin
                if (out_load) begin
                    state_next = dq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dq_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {1'b0, ovf_res_reg, res_empty, count_ext[4:0], back_val, front_val};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ===== sv/dq_check.sv =====
// dq_check: port-level assertions for double_ended_queue, bound to the top level
// depends on dq_pkg
`timescale 1ns / 1ps
`default_nettype none

module dq_check #(
    parameter int CAPACITY = dq_pkg::DEFAULT_CAPACITY
) (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_tvalid,
    input wire logic                         s_tready,
    input wire logic [dq_pkg::S_TDATA_W-1:0] s_tdata,
    input wire logic [dq_pkg::S_TUSER_W-1:0] s_tuser,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [dq_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam logic [31:0] CAP32 = 32'(CAPACITY);

    // a stalled result word stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[69] == (m_tdata[68:64] == 5'd0)) || (CAPACITY > 31))
        else $error("is_empty disagrees with count");

    a_empty_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[69] |-> (m_tdata[31:0] == dq_pkg::EMPTY_READ) &&
                                    (m_tdata[63:32] == dq_pkg::EMPTY_READ))
        else $error("empty queue does not read -1 at both ends");

    // a dropped push only happens on a full queue
    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[70] |-> (m_tdata[68:64] == CAP32[4:0]) && !m_tdata[69])
        else $error("overflow reported on a queue that is not full");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

endmodule

bind double_ended_queue dq_check #(.CAPACITY(CAPACITY)) u_dq_check (.*);

`default_nettype wire
